>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the modular inverse block.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/modinv_pkg.sv
// Package of the modular inverse block: widths, status codes and the
// command and status structs between controller and datapath. No dependencies.
`default_nettype none

package modinv_pkg;

    // Operand width and the width of the per-bit division counter.
    localparam int WIDTH = 32;
    localparam int CNT_W = $clog2(WIDTH);

    // Result status codes.
    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_NOT_COPRIME = 2'd1;
    localparam logic [1:0] STATUS_MOD_ZERO    = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture a new request and set up the iteration
        logic div_start;  // clear the divider for a new Euclid step
        logic div_step;   // one restoring-division bit and one Horner bit
        logic update;     // shift remainders and coefficients
        logic emit;       // load the result registers
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic m_zero;     // modulus of the current request is zero
        logic r1_zero;    // current divisor is zero, iteration is over
    } stat_t;

endpackage

`default_nettype wire

>>> rtl/modinv_intf.sv
// Request and result channel interfaces of the modular inverse block.
// Depends on modinv_pkg for the operand width.
`default_nettype none

interface modinv_in_if;
    import modinv_pkg::*;

    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] value;
    logic [WIDTH-1:0] modulus;

    modport source (output valid, output value, output modulus, input ready);
    modport sink (input valid, input value, input modulus, output ready);
endinterface

interface modinv_out_if;
    import modinv_pkg::*;

    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] inverse;
    logic [WIDTH-1:0] common_divisor;
    logic [1:0]       status;

    modport source (output valid, output inverse, output common_divisor, output status,
                    input ready);
    modport sink (input valid, input inverse, input common_divisor, input status,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/modinv_dp.sv
// Datapath of the modular inverse block: Euclid remainders, Bezout
// coefficients mod m, a bit-serial divider and the result registers. Uses modinv_pkg.
`default_nettype none

module modinv_dp (
    input  wire logic                         clk,
    input  wire modinv_pkg::cmd_t             cmd,
    input  wire logic [modinv_pkg::WIDTH-1:0] value,
    input  wire logic [modinv_pkg::WIDTH-1:0] modulus,
    output modinv_pkg::stat_t                 stat,
    output logic [modinv_pkg::WIDTH-1:0]      inverse,
    output logic [modinv_pkg::WIDTH-1:0]      common_divisor,
    output logic [1:0]                        status
);
    import modinv_pkg::*;

    logic [WIDTH-1:0] m_reg,   m_next;
    logic [WIDTH-1:0] r0_reg,  r0_next;
    logic [WIDTH-1:0] r1_reg,  r1_next;
    logic [WIDTH-1:0] s0_reg,  s0_next;
    logic [WIDTH-1:0] s1_reg,  s1_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] dvd_reg, dvd_next;
    logic [WIDTH-1:0] t_reg,   t_next;
    logic [WIDTH-1:0] inv_reg, inv_next;
    logic [WIDTH-1:0] gcd_reg, gcd_next;
    logic [1:0]       sts_reg, sts_next;

    logic [WIDTH:0]   rem_sh;
    logic [WIDTH:0]   rem_diff;
    logic             qbit;
    logic [WIDTH:0]   dbl;
    logic [WIDTH:0]   dbl_diff;
    logic [WIDTH-1:0] dbl_red;
    logic [WIDTH:0]   sum;
    logic [WIDTH:0]   sum_diff;
    logic [WIDTH-1:0] sum_red;
    logic [WIDTH-1:0] s_diff;

    // Restoring division: one quotient bit of r0 / r1 per step.
    assign rem_sh   = {rem_reg, dvd_reg[WIDTH-1]};
    assign rem_diff = rem_sh - {1'b0, r1_reg};
    assign qbit     = ~rem_diff[WIDTH];

    // Horner accumulation of s1 * q mod m, one quotient bit per step.
    assign dbl      = {t_reg, 1'b0};
    assign dbl_diff = dbl - {1'b0, m_reg};
    assign dbl_red  = dbl_diff[WIDTH] ? dbl[WIDTH-1:0] : dbl_diff[WIDTH-1:0];
    assign sum      = {1'b0, dbl_red} + {1'b0, s1_reg};
    assign sum_diff = sum - {1'b0, m_reg};
    assign sum_red  = sum_diff[WIDTH] ? sum[WIDTH-1:0] : sum_diff[WIDTH-1:0];

    // New coefficient s0 - s1 * q mod m; the add of m wraps back into range.
    assign s_diff = (s0_reg >= t_reg) ? (s0_reg - t_reg) : (s0_reg - t_reg + m_reg);

    // Next-state selection for all datapath registers.
    always_comb
    begin
        m_next   = m_reg;
        r0_next  = r0_reg;
        r1_next  = r1_reg;
        s0_next  = s0_reg;
        s1_next  = s1_reg;
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        t_next   = t_reg;
        inv_next = inv_reg;
        gcd_next = gcd_reg;
        sts_next = sts_reg;

        if (cmd.load)
        begin
            m_next  = modulus;
            r0_next = value;
            r1_next = modulus;
            s0_next = (modulus == WIDTH'(1)) ? '0 : WIDTH'(1);
            s1_next = '0;
        end

        if (cmd.div_start)
        begin
            rem_next = '0;
            dvd_next = r0_reg;
            t_next   = '0;
        end

        if (cmd.div_step)
        begin
            rem_next = qbit ? rem_diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
            dvd_next = {dvd_reg[WIDTH-2:0], 1'b0};
            t_next   = qbit ? sum_red : dbl_red;
        end

        if (cmd.update)
        begin
            r0_next = r1_reg;
            r1_next = rem_reg;
            s0_next = s1_reg;
            s1_next = s_diff;
        end

        if (cmd.emit)
        begin
            gcd_next = r0_reg;
            if (m_reg == '0)
            begin
                inv_next = '0;
                sts_next = STATUS_MOD_ZERO;
            end
            else
            begin
                inv_next = s0_reg;
                sts_next = (r0_reg == WIDTH'(1)) ? STATUS_OK : STATUS_NOT_COPRIME;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        m_reg   <= m_next;
        r0_reg  <= r0_next;
        r1_reg  <= r1_next;
        s0_reg  <= s0_next;
        s1_reg  <= s1_next;
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        t_reg   <= t_next;
        inv_reg <= inv_next;
        gcd_reg <= gcd_next;
        sts_reg <= sts_next;
    end

    assign stat.m_zero  = (m_reg == '0);
    assign stat.r1_zero = (r1_reg == '0);

    assign inverse        = inv_reg;
    assign common_divisor = gcd_reg;
    assign status         = sts_reg;

endmodule

`default_nettype wire

>>> rtl/modinv_ctrl.sv
// Controller of the modular inverse block: sequences Euclid steps and the
// bit-serial divider, and owns both handshakes. Uses modinv_pkg.
`default_nettype none

module modinv_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire modinv_pkg::stat_t stat,
    output modinv_pkg::cmd_t       cmd
);
    import modinv_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_UPDATE,
        S_FINISH
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic             out_valid_reg, out_valid_next;

    // Next state, counter and commands.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.m_zero || stat.r1_zero)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cnt_next      = '0;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WIDTH - 1))
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_CHECK;
            end
            S_FINISH:
            begin
                // Wait until the result register is free or being emptied.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> rtl/modular_inverse.sv
// Top level of the modular inverse block: controller, datapath and checks.
// Depends on modinv_pkg, modinv_intf, modinv_ctrl, modinv_dp and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// The block takes one request (value, modulus) at a time and returns the gcd,
// the Bezout coefficient of value reduced mod modulus (the inverse when the
// gcd is one) and a status code. Each Euclid step runs a bit-serial restoring
// divider that also accumulates the coefficient product mod m, one quotient
// bit per cycle. The number of Euclid steps is at most about 1.44 * WIDTH + 2,
// some 48 at 32 bits, and often far fewer. A zero modulus goes from the check
// straight to the finish state. A new request is taken as soon as the previous
// one has finished, even while its result still waits in the output register.
module modular_inverse (
    input  wire logic    clk,
    input  wire logic    rst_n,
    modinv_in_if.sink    in_ch,
    modinv_out_if.source out_ch
);
    import modinv_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    modinv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    modinv_dp u_dp (
        .clk            (clk),
        .cmd            (cmd),
        .value          (in_ch.value),
        .modulus        (in_ch.modulus),
        .stat           (stat),
        .inverse        (out_ch.inverse),
        .common_divisor (out_ch.common_divisor),
        .status         (out_ch.status)
    );

    // A zero modulus always reports a zero inverse.
    `ASSERT_IMPLIES(a_mod_zero_inv, clk, rst_n, out_ch.valid && (out_ch.status == STATUS_MOD_ZERO), out_ch.inverse == '0)
    // A valid inverse implies a gcd of one.
    `ASSERT_IMPLIES(a_ok_gcd_one, clk, rst_n, out_ch.valid && (out_ch.status == STATUS_OK), out_ch.common_divisor == WIDTH'(1))
    // An accepted request takes the block out of its idle state.
    `ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
    // A new request is never taken while the result path is being loaded.
    `ASSERT_IMPLIES(a_no_load_emit, clk, rst_n, cmd.emit, !cmd.load)

endmodule

`default_nettype wire

>>> sim/tb.sv
// Self-checking testbench for the modular inverse block (extended Euclid).
// Depends on modinv_pkg, modinv_intf and the modular_inverse RTL; standalone otherwise.
`timescale 1ns / 100ps

module tb;
    import modinv_pkg::*;

    // Drain time after the last result, sized for a request with the longest Euclid chain.
    localparam int DRAIN_CYCLES = 2000;
    // Cycles with no handshake on either side before the run is declared hung.
    localparam int HANG_LIMIT   = 12000;
    // Length of each long back-pressure window on the result side.
    localparam int HOLD_CYCLES  = 4000;
    localparam int RANDOM_REQS  = 750;
    localparam int MAX_PRINTED  = 60;

    typedef struct packed {
        logic [WIDTH-1:0] value;
        logic [WIDTH-1:0] modulus;
    } inverse_request_t;

    typedef struct packed {
        logic [WIDTH-1:0] inverse;
        logic [WIDTH-1:0] common_divisor;
        logic [1:0]       status;
    } inverse_result_t;

    logic clk = 1'b0;
    logic rst_n;

    inverse_request_t pending_requests[$];
    inverse_result_t  expected_results[$];

    int error_count   = 0;
    int send_gap      = 0;
    int send_burst    = 0;
    int recv_gap      = 0;
    int recv_burst    = 0;
    int hold_left     = 0;
    int results_taken = 0;
    int idle_cycles   = 0;

    modinv_in_if  req_ch ();
    modinv_out_if res_ch ();

    modular_inverse dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (req_ch),
        .out_ch (res_ch)
    );

    // Clock with a 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Extended Euclid with the coefficient of value kept modulo the modulus.
    function automatic inverse_result_t compute_inverse(input logic [WIDTH-1:0] value,
                                                        input logic [WIDTH-1:0] modulus);
        inverse_result_t    res;
        logic [2*WIDTH-1:0] m;
        logic [2*WIDTH-1:0] rem_a;
        logic [2*WIDTH-1:0] rem_b;
        logic [2*WIDTH-1:0] rem_n;
        logic [2*WIDTH-1:0] coef_a;
        logic [2*WIDTH-1:0] coef_b;
        logic [2*WIDTH-1:0] coef_n;
        logic [2*WIDTH-1:0] quot;
        logic [2*WIDTH-1:0] prod;
        m = {{WIDTH{1'b0}}, modulus};
        if (modulus == '0)
        begin
            res.inverse        = '0;
            res.common_divisor = value;
            res.status         = STATUS_MOD_ZERO;
            return res;
        end
        rem_a  = {{WIDTH{1'b0}}, value};
        rem_b  = m;
        coef_a = (m == 1) ? '0 : 1;
        coef_b = '0;
        while (rem_b != '0)
        begin
            quot   = rem_a / rem_b;
            rem_n  = rem_a % rem_b;
            // Both factors are below 2^WIDTH, so the product cannot overflow.
            prod   = (coef_b * (quot % m)) % m;
            coef_n = (coef_a >= prod) ? coef_a - prod : coef_a + (m - prod);
            rem_a  = rem_b;
            rem_b  = rem_n;
            coef_a = coef_b;
            coef_b = coef_n;
        end
        res.inverse        = coef_a[WIDTH-1:0];
        res.common_divisor = rem_a[WIDTH-1:0];
        res.status         = (rem_a == 1) ? STATUS_OK : STATUS_NOT_COPRIME;
        return res;
    endfunction

    // Mostly short gaps, a few long ones, and now and then a stretch with none.
    function automatic int next_gap(inout int burst_left);
        int roll;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(99) < 3)
            burst_left = $urandom_range(20, 60);
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 16);
        else
            return $urandom_range(30, 120);
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTED)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    // Request driver: predicts each accepted request and offers the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid   <= 1'b0;
            req_ch.value   <= '0;
            req_ch.modulus <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                expected_results.push_back(compute_inverse(req_ch.value, req_ch.modulus));
                send_gap = next_gap(send_burst);
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    req_ch.value   <= pending_requests[0].value;
                    req_ch.modulus <= pending_requests[0].modulus;
                    req_ch.valid   <= 1'b1;
                    void'(pending_requests.pop_front());
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each accepted result with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result inverse=%h gcd=%h status=%0d",
                                              res_ch.inverse, res_ch.common_divisor,
                                              res_ch.status));
                end
                else
                begin
                    if (res_ch.inverse !== expected_results[0].inverse)
                        report_mismatch($sformatf("inverse got %h expected %h",
                                                  res_ch.inverse,
                                                  expected_results[0].inverse));
                    if (res_ch.common_divisor !== expected_results[0].common_divisor)
                        report_mismatch($sformatf("common_divisor got %h expected %h",
                                                  res_ch.common_divisor,
                                                  expected_results[0].common_divisor));
                    if (res_ch.status !== expected_results[0].status)
                        report_mismatch($sformatf("status got %0d expected %0d",
                                                  res_ch.status,
                                                  expected_results[0].status));
                    void'(expected_results.pop_front());
                end
                recv_gap = next_gap(recv_burst);
            end
            if (hold_left > 0)
                res_ch.ready <= 1'b0;
            else if (recv_gap > 0)
            begin
                recv_gap--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // Long back-pressure windows, so the block fills up and stalls its requests.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left     <= 0;
            results_taken <= 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
                results_taken <= results_taken + 1;
            if (hold_left > 0)
                hold_left <= hold_left - 1;
            else if (res_ch.valid && res_ch.ready
                     && (results_taken == 60 || results_taken == 500))
                hold_left <= HOLD_CYCLES;
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= HANG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        inverse_request_t req;
        logic [31:0]      factor;
        int               roll;

        rst_n = 1'b0;

        // Directed requests: zero and unit moduli, zero value, value not below
        // the modulus, shared factors, field extremes and the longest chain.
        pending_requests.push_back('{32'h0000_0000, 32'h0000_0000});
        pending_requests.push_back('{32'hFFFF_FFFF, 32'h0000_0000});
        pending_requests.push_back('{32'h0000_3039, 32'h0000_0000});
        pending_requests.push_back('{32'h0000_0000, 32'h0000_0001});
        pending_requests.push_back('{32'hFFFF_FFFF, 32'h0000_0001});
        pending_requests.push_back('{32'h0000_0000, 32'h0000_0061});
        pending_requests.push_back('{32'h0000_0000, 32'hFFFF_FFFF});
        pending_requests.push_back('{32'h0000_0003, 32'h0000_0007});
        pending_requests.push_back('{32'h0000_000A, 32'h0000_0007});
        pending_requests.push_back('{32'h0000_0007, 32'h0000_0007});
        pending_requests.push_back('{32'h0000_0006, 32'h0000_0009});
        pending_requests.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFE});
        pending_requests.push_back('{32'hFFFF_FFFE, 32'hFFFF_FFFF});
        pending_requests.push_back('{32'h0000_0002, 32'hFFFF_FFFF});
        pending_requests.push_back('{32'h8000_0000, 32'hFFFF_FFFF});
        pending_requests.push_back('{32'h0000_0001, 32'hFFFF_FFFF});
        pending_requests.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF});
        pending_requests.push_back('{32'd1836311903, 32'd2971215073});
        pending_requests.push_back('{32'd2971215073, 32'd1836311903});
        pending_requests.push_back('{32'h0001_0000, 32'hFFFF_FFFB});
        pending_requests.push_back('{32'h8000_0000, 32'h4000_0000});
        pending_requests.push_back('{32'h0000_0001, 32'h0000_0002});
        pending_requests.push_back('{32'h0000_0005, 32'h7FFF_FFFF});

        // Random requests in several flavors; short operands keep most chains short.
        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 30)
            begin
                req.value   = $urandom;
                req.modulus = $urandom;
            end
            else if (roll < 55)
            begin
                req.value   = $urandom >> $urandom_range(0, 31);
                req.modulus = $urandom >> $urandom_range(0, 31);
            end
            else if (roll < 65)
            begin
                factor      = $urandom_range(2, 4096);
                req.value   = factor * $urandom_range(0, 32'hFFFF_FFFF / factor);
                req.modulus = factor * $urandom_range(1, 32'hFFFF_FFFF / factor);
            end
            else if (roll < 75)
            begin
                req.value   = ($urandom_range(3) == 0) ? 32'h0 : $urandom;
                req.modulus = $urandom_range(0, 2);
            end
            else if (roll < 90)
            begin
                req.value = $urandom >> $urandom_range(0, 8);
                case ($urandom_range(4))
                    0:       req.modulus = 32'd4294967291;
                    1:       req.modulus = 32'd2147483647;
                    2:       req.modulus = 32'd65521;
                    3:       req.modulus = 32'd251;
                    default: req.modulus = 32'd1000000007;
                endcase
            end
            else
            begin
                req.modulus = $urandom;
                req.value   = req.modulus + (($urandom_range(1) == 0) ? 32'h1 : 32'hFFFF_FFFF);
            end
            pending_requests.push_back(req);
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() != 0 || req_ch.valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/modinv_pkg.sv
rtl/modinv_intf.sv
rtl/modinv_dp.sv
rtl/modinv_ctrl.sv
rtl/modular_inverse.sv
sim/tb.sv
